@@ rtl/lzte_pkg.sv @@
`timescale 1ns / 1ps

package lzte_pkg;

  // Dictionary geometry. DICT_DEPTH is taken to be a power of two of at least
  // 32, so that an entry index splits cleanly into a bank row and a cell number.
  localparam int DICT_DEPTH = 4096;
  localparam int N_CELLS    = 16;
  localparam int CELL_W     = $clog2(N_CELLS);
  localparam int IDX_W      = $clog2(DICT_DEPTH);
  localparam int ROW_W      = IDX_W - CELL_W;
  localparam int ROWS       = DICT_DEPTH / N_CELLS;
  localparam int NFI_W      = $clog2(DICT_DEPTH + 1);
  localparam int ENT_W      = IDX_W + 8;

  // Fixed field widths of the ports.
  localparam int BYTE_W     = 8;
  localparam int PREFIX_W   = 12;
  localparam int LIM_W      = 13;

  localparam logic [LIM_W-1:0] CFG_LIMIT_RESET = 13'd4096;

  // Command word broadcast from the controller to every cell.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [CELL_W-1:0] wr_cell;
    logic [ROW_W-1:0]  row;
    logic [ENT_W-1:0]  key;
    logic [NFI_W-1:0]  nfi;
  } bcast_t;

  // Hit record handed from cell to cell.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } hit_t;

endpackage

@@ rtl/lzte_ram.sv @@
`timescale 1ns / 1ps

module lzte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lzte_cell.sv @@
`timescale 1ns / 1ps

module lzte_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lzte_pkg::CELL_W-1:0]   cell_id_i,
  input  lzte_pkg::bcast_t              bc_i,
  input  lzte_pkg::hit_t                hit_i,
  output lzte_pkg::hit_t                hit_o
);

  localparam int NFI_W = lzte_pkg::NFI_W;

  logic [lzte_pkg::ENT_W-1:0] rdata;
  logic                       rd_q;
  logic [lzte_pkg::ROW_W-1:0] row_q;
  logic [lzte_pkg::IDX_W-1:0] local_idx;
  logic                       local_hit;
  lzte_pkg::hit_t             hit_q;

  // Entry index i lives in cell i mod N_CELLS at row i / N_CELLS.
  lzte_ram #(
    .WIDTH(lzte_pkg::ENT_W),
    .DEPTH(lzte_pkg::ROWS)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (bc_i.wr && (bc_i.wr_cell == cell_id_i)),
    .waddr_i (bc_i.row),
    .wdata_i (bc_i.key),
    .re_i    (bc_i.rd),
    .raddr_i (bc_i.row),
    .rdata_o (rdata)
  );

  assign local_idx = {row_q, cell_id_i};

  // Only entries 1 .. nfi-1 belong to the current stream.
  assign local_hit = rd_q && (rdata == bc_i.key) && (local_idx != '0) &&
                     (NFI_W'(local_idx) < bc_i.nfi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      row_q <= '0;
      hit_q <= '0;
    end else begin
      rd_q  <= bc_i.rd;
      row_q <= bc_i.row;
      // A pair is stored at most once per stream, so a local hit never
      // collides with a record coming in from the neighbor.
      if (local_hit) begin
        hit_q.found <= 1'b1;
        hit_q.idx   <= local_idx;
      end else begin
        hit_q <= hit_i;
      end
    end
  end

  assign hit_o = hit_q;

endmodule

@@ rtl/lz78_token_encoder.sv @@
`timescale 1ns / 1ps
// LZ78 token encoder. For each accepted item the encoder scans the bank rows of the current
// stream (ceil(next index / 16) rows, 1 to 256), lets the hit record leave the 16-cell
// chain and then decides; a matched item that is not the last yields no token.
// One item is in work at a time, so a new item is taken only once the last is decided;
// a decision that emits a token waits while the output register holds an untaken token.
// Reset sets the limit to 4096 and the next index to one; the banks are not cleared.

module lz78_token_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lzte_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lzte_pkg::PREFIX_W-1:0] prefix_index_o,
  output logic [lzte_pkg::BYTE_W-1:0]   literal_byte_o,
  output logic                          stream_end_o,
  input  logic                          cfg_we_i,
  input  logic [lzte_pkg::LIM_W-1:0]    cfg_wdata_i
);

  localparam int N_CELLS  = lzte_pkg::N_CELLS;
  localparam int CELL_W   = lzte_pkg::CELL_W;
  localparam int IDX_W    = lzte_pkg::IDX_W;
  localparam int ROW_W    = lzte_pkg::ROW_W;
  localparam int NFI_W    = lzte_pkg::NFI_W;
  localparam int LIM_W    = lzte_pkg::LIM_W;
  localparam int PW       = lzte_pkg::PREFIX_W;
  localparam int CMP_W    = (NFI_W > LIM_W) ? NFI_W : LIM_W;
  localparam int CNT_W    = $clog2(N_CELLS + 1);
  localparam logic [CNT_W-1:0] DRAIN_LEN = CNT_W'(N_CELLS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  state_e                          state_q;
  logic [LIM_W-1:0]                lim_q;
  logic [IDX_W-1:0]                cur_q;
  logic [NFI_W-1:0]                nfi_q;
  logic                            last_q;
  logic [lzte_pkg::BYTE_W-1:0]     byte_q;
  logic [lzte_pkg::ENT_W-1:0]      key_q;
  logic                            rd_q;
  logic                            wr_q;
  logic [CELL_W-1:0]               wr_cell_q;
  logic [ROW_W-1:0]                row_q;
  logic [CNT_W-1:0]                cnt_q;
  logic                            found_q;
  logic [IDX_W-1:0]                hit_idx_q;
  logic                            out_valid_q;
  logic [PW-1:0]                   out_prefix_q;
  logic [lzte_pkg::BYTE_W-1:0]     out_byte_q;
  logic                            out_end_q;

  logic [NFI_W-1:0]                nfi_m1;
  logic [ROW_W-1:0]                last_row;
  logic                            can_insert;
  lzte_pkg::bcast_t                bc;
  lzte_pkg::hit_t                  chain [N_CELLS+1];

  assign nfi_m1   = nfi_q - NFI_W'(1);
  assign last_row = nfi_m1[IDX_W-1:CELL_W];

  // The effective limit is the smaller of the register and the table depth.
  assign can_insert = (CMP_W'(nfi_q) < CMP_W'(lim_q)) &&
                      (nfi_q < NFI_W'(lzte_pkg::DICT_DEPTH));

  assign bc.rd      = rd_q;
  assign bc.wr      = wr_q;
  assign bc.wr_cell = wr_cell_q;
  assign bc.row     = row_q;
  assign bc.key     = key_q;
  assign bc.nfi     = nfi_q;

  assign chain[0] = '0;

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    lzte_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CELL_W'(g)),
      .bc_i      (bc),
      .hit_i     (chain[g]),
      .hit_o     (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= lzte_pkg::CFG_LIMIT_RESET;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      nfi_q        <= NFI_W'(1);
      last_q       <= 1'b0;
      byte_q       <= '0;
      key_q        <= '0;
      rd_q         <= 1'b0;
      wr_q         <= 1'b0;
      wr_cell_q    <= '0;
      row_q        <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      hit_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_prefix_q <= '0;
      out_byte_q   <= '0;
      out_end_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Catch the hit record as it leaves the end of the chain.
      if (chain[N_CELLS].found) begin
        found_q   <= 1'b1;
        hit_idx_q <= chain[N_CELLS].idx;
      end

      unique case (state_q)
        ST_IDLE: begin
          wr_q <= 1'b0;
          if (in_valid_i) begin
            byte_q  <= data_byte_i;
            last_q  <= last_byte_i;
            key_q   <= {cur_q, data_byte_i};
            rd_q    <= 1'b1;
            row_q   <= '0;
            found_q <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (row_q == last_row) begin
            rd_q    <= 1'b0;
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end
        ST_DRAIN: begin
          if (cnt_q == DRAIN_LEN) begin
            state_q <= ST_DECIDE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DECIDE: begin
          if (found_q && !last_q) begin
            cur_q   <= hit_idx_q;
            state_q <= ST_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_prefix_q <= PW'(cur_q);
            out_byte_q   <= byte_q;
            out_end_q    <= last_q;
            if (can_insert) begin
              // key_q already holds the pair to store.
              wr_q      <= 1'b1;
              wr_cell_q <= nfi_q[CELL_W-1:0];
              row_q     <= nfi_q[IDX_W-1:CELL_W];
            end
            cur_q <= '0;
            if (last_q) begin
              nfi_q <= NFI_W'(1);
            end else if (can_insert) begin
              nfi_q <= nfi_q + NFI_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign prefix_index_o = out_prefix_q;
  assign literal_byte_o = out_byte_q;
  assign stream_end_o   = out_end_q;

endmodule
